FILE: sv/masp_pkg.sv
// shared constants and types for the moving average sign pwm led drive block
package masp_pkg;

    localparam int WINDOW_LEN_DEF  = 16;
    localparam int PWM_STEPS_DEF   = 100;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int OFFSET_BITS     = 12;
    localparam int FULL_SCALE_DEV  = 1000;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_POS  = 2'd1,
        MODE_NEG  = 2'd2
    } mode_t;

endpackage

FILE: sv/masp_window_cell.sv
// one window cell: holds a sample and hands it to the next cell on each request
module masp_window_cell #(
    parameter int SAMPLE_BITS = masp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  logic [SAMPLE_BITS-1:0] d_in,
    output logic [SAMPLE_BITS-1:0] d_out
);

    logic [SAMPLE_BITS-1:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (shift_en) begin
            sample_reg <= d_in;
        end
    end

    assign d_out = sample_reg;

endmodule

FILE: sv/masp_window_row.sv
// row of window cells forming the sample delay line, oldest sample at the end
module masp_window_row #(
    parameter int WINDOW_LEN  = masp_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = masp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    output logic [SAMPLE_BITS-1:0] oldest
);

    logic [SAMPLE_BITS-1:0] tap [WINDOW_LEN+1];

    assign tap[0] = sample_in;

    for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
        masp_window_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift_en(shift_en),
            .d_in    (tap[i]),
            .d_out   (tap[i+1])
        );
    end

    assign oldest = tap[WINDOW_LEN];

endmodule

FILE: sv/masp_duty_pipe.sv
// pipeline from window sum to mode, duty compare and led levels
module masp_duty_pipe #(
    parameter int WINDOW_LEN  = masp_pkg::WINDOW_LEN_DEF,
    parameter int PWM_STEPS   = masp_pkg::PWM_STEPS_DEF,
    parameter int SAMPLE_BITS = masp_pkg::SAMPLE_BITS_DEF,
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN),
    localparam int CNT_W = $clog2(PWM_STEPS),
    localparam int CMP_W = $clog2(PWM_STEPS + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [SUM_W-1:0]                  in_total,
    input  logic [CNT_W-1:0]                  in_cnt,
    input  logic                              mod_en,
    input  logic [masp_pkg::OFFSET_BITS-1:0]  dc_offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [SUM_W-1:0]                  out_total,
    output masp_pkg::mode_t                   out_mode,
    output logic [CMP_W-1:0]                  out_cmp,
    output logic                              out_led_pos,
    output logic                              out_led_neg
);

    localparam int LVL_W  = masp_pkg::OFFSET_BITS + $clog2(WINDOW_LEN);
    localparam int DIFF_W = (SUM_W > LVL_W) ? SUM_W : LVL_W;
    localparam int DIV    = WINDOW_LEN * masp_pkg::FULL_SCALE_DEV;
    localparam int DEV_W  = $clog2(DIV);
    localparam int DW     = (DIFF_W > DEV_W) ? DIFF_W : DEV_W;
    localparam int K      = $clog2(PWM_STEPS * DIV);
    localparam int RECIP  = (1 << K) / DIV;
    localparam int M_W    = $clog2(RECIP + 1);
    localparam int QM_W   = K + M_W;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [CNT_W-1:0] cnt;
        masp_pkg::mode_t  mode;
    } side_t;

    logic            v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic            r1, r2, r3, r4, r5, r6;
    side_t           s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;

    logic [DIFF_W-1:0] dev1_reg;
    logic              sat2_reg, sat3_reg, sat4_reg;
    logic [K-1:0]      prod2_reg, prod3_reg, prod4_reg;
    logic [QM_W-1:0]   qm3_reg;
    logic [CMP_W-1:0]  q04_reg;
    logic [K-1:0]      qd4_reg;
    logic [CMP_W-1:0]  cmp5_reg;

    logic [SUM_W-1:0]  total6_reg;
    masp_pkg::mode_t   mode6_reg;
    logic [CMP_W-1:0]  cmp6_reg;
    logic              led_pos6_reg, led_neg6_reg;

    logic [DIFF_W-1:0] lvl1, tot1, dev1_next;
    logic              pos1;
    side_t             s1_next;
    logic [DW-1:0]     dev_ext;
    logic [DEV_W-1:0]  dev_lo;
    logic [K-1:0]      rem5;
    logic [CMP_W-1:0]  q5, cmp5_next;
    logic              lit6;

    assign r6 = !v6_reg || out_ready;
    assign r5 = !v5_reg || r6;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_comb begin
        lvl1 = DIFF_W'(dc_offset) * DIFF_W'(WINDOW_LEN);
        tot1 = DIFF_W'(in_total);
        pos1 = tot1 > lvl1;
        dev1_next = pos1 ? (tot1 - lvl1) : (lvl1 - tot1);
        s1_next.total = in_total;
        s1_next.cnt   = in_cnt;
        if (!mod_en) begin
            s1_next.mode = masp_pkg::MODE_IDLE;
        end else if (pos1) begin
            s1_next.mode = masp_pkg::MODE_POS;
        end else begin
            s1_next.mode = masp_pkg::MODE_NEG;
        end
    end

    assign dev_ext = DW'(dev1_reg);
    assign dev_lo  = dev_ext[DEV_W-1:0];

    always_comb begin
        rem5 = prod4_reg - qd4_reg;
        q5   = q04_reg + CMP_W'(rem5 >= K'(DIV));
        if (s4_reg.mode == masp_pkg::MODE_IDLE) begin
            cmp5_next = '0;
        end else if (sat4_reg) begin
            cmp5_next = CMP_W'(PWM_STEPS);
        end else begin
            cmp5_next = q5;
        end
    end

    assign lit6 = CMP_W'(s5_reg.cnt) < cmp5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
            if (r6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1) begin
            s1_reg   <= s1_next;
            dev1_reg <= dev1_next;
        end
        if (r2) begin
            s2_reg    <= s1_reg;
            sat2_reg  <= dev_ext >= DW'(DIV);
            prod2_reg <= K'(dev_lo) * K'(PWM_STEPS);
        end
        if (r3) begin
            s3_reg    <= s2_reg;
            sat3_reg  <= sat2_reg;
            prod3_reg <= prod2_reg;
            qm3_reg   <= QM_W'(prod2_reg) * QM_W'(RECIP);
        end
        if (r4) begin
            s4_reg    <= s3_reg;
            sat4_reg  <= sat3_reg;
            prod4_reg <= prod3_reg;
            q04_reg   <= qm3_reg[K +: CMP_W];
            qd4_reg   <= K'(qm3_reg[K +: CMP_W]) * K'(DIV);
        end
        if (r5) begin
            s5_reg   <= s4_reg;
            cmp5_reg <= cmp5_next;
        end
        if (r6) begin
            total6_reg   <= s5_reg.total;
            mode6_reg    <= s5_reg.mode;
            cmp6_reg     <= cmp5_reg;
            led_pos6_reg <= !(lit6 && (s5_reg.mode == masp_pkg::MODE_POS));
            led_neg6_reg <= !(lit6 && (s5_reg.mode == masp_pkg::MODE_NEG));
        end
    end

    assign out_valid   = v6_reg;
    assign out_total   = total6_reg;
    assign out_mode    = mode6_reg;
    assign out_cmp     = cmp6_reg;
    assign out_led_pos = led_pos6_reg;
    assign out_led_neg = led_neg6_reg;

endmodule

FILE: sv/moving_average_sign_pwm_led_drive_core.sv
// top level: moving average window, pwm counter and duty pipeline
// an accepted request passes through the six duty pipeline registers before its result reaches m_tvalid
// throughput: one request per cycle while m_tready does not stall the six-stage duty pipeline
// the running sum and pwm counter update in the cycle a request is accepted
// reset (aresetn low, synchronous) clears the window cells, sum, pwm counter,
// pipeline valids, and loads modulation_enable 1 and dc_offset 2048
module moving_average_sign_pwm_led_drive_core #(
    parameter int WINDOW_LEN  = masp_pkg::WINDOW_LEN_DEF,
    parameter int PWM_STEPS   = masp_pkg::PWM_STEPS_DEF,
    parameter int SAMPLE_BITS = masp_pkg::SAMPLE_BITS_DEF,
    localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW_LEN),
    localparam int CMP_W     = $clog2(PWM_STEPS + 1),
    localparam int S_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = SUM_W + 2 + CMP_W + 2,
    localparam int M_DATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [masp_pkg::OFFSET_BITS-1:0] cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // raw_sample
    input  logic [S_DATA_W-1:0]              s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // average_x16, mode, duty_compare, led_pos_level, led_neg_level
    output logic [M_DATA_W-1:0]              m_tdata
);

    localparam int CNT_W = $clog2(PWM_STEPS);
    localparam logic REG_MOD_ENABLE = 1'b0;
    localparam logic REG_DC_OFFSET  = 1'b1;

    logic                             mod_en_reg;
    logic [masp_pkg::OFFSET_BITS-1:0] dc_offset_reg;
    logic [SUM_W-1:0]                 sum_reg, sum_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0]           sample, oldest;
    logic                             accept;

    logic [SUM_W-1:0]  out_total;
    masp_pkg::mode_t   out_mode;
    logic [CMP_W-1:0]  out_cmp;
    logic              out_led_pos, out_led_neg;

    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign accept   = s_tvalid && s_tready;
    assign sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(sample);
    assign cnt_next = (cnt_reg == CNT_W'(PWM_STEPS - 1)) ? '0 : cnt_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_en_reg    <= 1'b1;
            dc_offset_reg <= masp_pkg::OFFSET_BITS'(2048);
            sum_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MOD_ENABLE: mod_en_reg    <= cfg_data[0];
                    REG_DC_OFFSET:  dc_offset_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    masp_window_row #(
        .WINDOW_LEN (WINDOW_LEN),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (accept),
        .sample_in(sample),
        .oldest   (oldest)
    );

    masp_duty_pipe #(
        .WINDOW_LEN (WINDOW_LEN),
        .PWM_STEPS  (PWM_STEPS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_total   (sum_next),
        .in_cnt     (cnt_next),
        .mod_en     (mod_en_reg),
        .dc_offset  (dc_offset_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_total  (out_total),
        .out_mode   (out_mode),
        .out_cmp    (out_cmp),
        .out_led_pos(out_led_pos),
        .out_led_neg(out_led_neg)
    );

    assign m_tdata = M_DATA_W'({out_led_neg, out_led_pos, out_cmp, out_mode, out_total});

endmodule

FILE: sv/masp_checker.sv
// port-level checks on the result channel of the core, bound to the top level
module masp_checker #(
    parameter int WINDOW_LEN  = masp_pkg::WINDOW_LEN_DEF,
    parameter int PWM_STEPS   = masp_pkg::PWM_STEPS_DEF,
    parameter int SAMPLE_BITS = masp_pkg::SAMPLE_BITS_DEF,
    localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW_LEN),
    localparam int CMP_W    = $clog2(PWM_STEPS + 1),
    localparam int OUT_BITS = SUM_W + 2 + CMP_W + 2,
    localparam int M_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic [1:0]       mode;
    logic [CMP_W-1:0] duty;
    logic             led_pos, led_neg;

    assign mode    = m_tdata[SUM_W +: 2];
    assign duty    = m_tdata[SUM_W + 2 +: CMP_W];
    assign led_pos = m_tdata[SUM_W + 2 + CMP_W];
    assign led_neg = m_tdata[SUM_W + 3 + CMP_W];

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> duty <= CMP_W'(PWM_STEPS))
        else $error("duty compare above period");

    a_idle_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && mode == masp_pkg::MODE_IDLE) |-> (duty == '0 && led_pos && led_neg))
        else $error("idle result with lit led or nonzero duty");

    a_one_led: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (led_pos || led_neg))
        else $error("both leds lit");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind moving_average_sign_pwm_led_drive_core masp_checker #(
    .WINDOW_LEN (WINDOW_LEN),
    .PWM_STEPS  (PWM_STEPS),
    .SAMPLE_BITS(SAMPLE_BITS)
) u_masp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

FILE: verif/masp_tb_pkg.sv
// register index codes shared by the testbench top and its checker
`timescale 1ns / 100ps

package masp_tb_pkg;

    typedef enum logic {
        REG_MOD_ENABLE = 1'b0,
        REG_DC_OFFSET  = 1'b1
    } cfg_reg_t;

endpackage

FILE: verif/moving_average_sign_pwm_led_drive_checker.sv
// checker: predicts the filtered average and led drive per sample and compares results
`timescale 1ns / 100ps

module moving_average_sign_pwm_led_drive_checker #(
    parameter int S_W = 16,
    parameter int M_W = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [masp_pkg::OFFSET_BITS-1:0] cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // raw_sample
    input  logic [S_W-1:0]                   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // average_x16, mode, duty_compare, led_pos_level, led_neg_level
    input  logic [M_W-1:0]                   m_tdata,
    output int                               fail_count,
    output int                               pending
);

    localparam int WIN   = masp_pkg::WINDOW_LEN_DEF;
    localparam int STEPS = masp_pkg::PWM_STEPS_DEF;
    localparam int SBITS = masp_pkg::SAMPLE_BITS_DEF;

    typedef struct {
        logic [15:0]     average_x16;
        masp_pkg::mode_t mode;
        logic [6:0]      duty_compare;
        logic            led_pos_level;
        logic            led_neg_level;
    } led_drive_t;

    logic [SBITS-1:0]                 window_cells [WIN];
    logic [3:0]                       fill_slot;
    logic [15:0]                      window_sum;
    int                               pwm_phase;
    logic                             mod_enable;
    logic [masp_pkg::OFFSET_BITS-1:0] offset_level;
    led_drive_t                       drive_expect [$];
    int                               mismatches = 0;
    int                               waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    task automatic predict_drive(input logic [SBITS-1:0] smp);
        led_drive_t d;
        int level;
        int total;
        int dev;
        int cmp;
        window_sum = window_sum - 16'(window_cells[fill_slot]) + 16'(smp);
        window_cells[fill_slot] = smp;
        fill_slot = fill_slot + 4'd1;
        pwm_phase = pwm_phase + 1;
        if (pwm_phase >= STEPS) begin
            pwm_phase = 0;
        end
        d.average_x16   = window_sum;
        d.mode          = masp_pkg::MODE_IDLE;
        d.duty_compare  = '0;
        d.led_pos_level = 1'b1;
        d.led_neg_level = 1'b1;
        if (mod_enable) begin
            level = WIN * int'(offset_level);
            total = int'(window_sum);
            if (total > level) begin
                d.mode = masp_pkg::MODE_POS;
                dev = total - level;
            end else begin
                d.mode = masp_pkg::MODE_NEG;
                dev = level - total;
            end
            cmp = (dev * STEPS) / (WIN * masp_pkg::FULL_SCALE_DEV);
            if (cmp > STEPS) begin
                cmp = STEPS;
            end
            d.duty_compare = 7'(cmp);
            if (pwm_phase < cmp) begin
                if (d.mode == masp_pkg::MODE_POS) begin
                    d.led_pos_level = 1'b0;
                end else begin
                    d.led_neg_level = 1'b0;
                end
            end
        end
        drive_expect.push_back(d);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        led_drive_t e;
        if (!aresetn) begin
            for (int i = 0; i < WIN; i++) begin
                window_cells[i] = '0;
            end
            fill_slot    = '0;
            window_sum   = '0;
            pwm_phase    = 0;
            mod_enable   = 1'b1;
            offset_level = 12'd2048;
            drive_expect.delete();
        end else begin
            if (cfg_wr_en) begin
                case (masp_tb_pkg::cfg_reg_t'(cfg_index))
                    masp_tb_pkg::REG_MOD_ENABLE: mod_enable = cfg_data[0];
                    masp_tb_pkg::REG_DC_OFFSET:  offset_level = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (drive_expect.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    e = drive_expect.pop_front();
                    check_field("average_x16", e.average_x16, m_tdata[15:0]);
                    check_field("mode", int'(e.mode), m_tdata[17:16]);
                    check_field("duty_compare", e.duty_compare, m_tdata[24:18]);
                    check_field("led_pos_level", e.led_pos_level, m_tdata[25]);
                    check_field("led_neg_level", e.led_neg_level, m_tdata[26]);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_drive(s_tdata[SBITS-1:0]);
            end
        end
        waiting = drive_expect.size();
    end

endmodule

FILE: verif/moving_average_sign_pwm_led_drive_core_test.sv
// testbench top: drives samples and register writes, gives the verdict
`timescale 1ns / 100ps

module moving_average_sign_pwm_led_drive_core_test;

    localparam int S_W   = ((masp_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int OUT_B = masp_pkg::SAMPLE_BITS_DEF + $clog2(masp_pkg::WINDOW_LEN_DEF) + 2
                           + $clog2(masp_pkg::PWM_STEPS_DEF + 1) + 2;
    localparam int M_W   = ((OUT_B + 7) / 8) * 8;
    localparam int LIMIT = 200000;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic                             cfg_index = 1'b0;
    logic [masp_pkg::OFFSET_BITS-1:0] cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [S_W-1:0]                   s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [M_W-1:0]                   m_tdata;
    int                               fail_count;
    int                               pending;
    int                               cycles = 0;
    logic                             calm = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    moving_average_sign_pwm_led_drive_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    moving_average_sign_pwm_led_drive_checker #(
        .S_W (S_W),
        .M_W (M_W)
    ) u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 6) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge aclk);
        end
    end

    task automatic send_sample(input logic [11:0] smp, input int gap_pct);
        s_tdata  = S_W'(smp);
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
    endtask

    task automatic drain_requests();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_regs(input logic en, input logic [masp_pkg::OFFSET_BITS-1:0] off);
        cfg_wr_en = 1'b1;
        cfg_index = masp_tb_pkg::REG_MOD_ENABLE;
        cfg_data  = {11'($urandom_range(0, 2047)), en};
        @(negedge aclk);
        cfg_index = masp_tb_pkg::REG_DC_OFFSET;
        cfg_data  = off;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // runs of steady levels (around the offset, at an extreme or at a random level), with random noise mixed in
    task automatic run_phase(input logic en, input int off, input int count);
        int sent;
        int kind;
        int target;
        int run_len;
        int v;
        int gap_pct;
        sent = 0;
        gap_pct = $urandom_range(0, 40);
        drain_requests();
        set_regs(en, 12'(off));
        while (sent < count) begin
            kind    = $urandom_range(0, 9);
            run_len = $urandom_range(1, 24);
            if (kind <= 5) begin
                target = off + $urandom_range(0, 2200) - 1100;
            end else if (kind == 6) begin
                target = $urandom_range(0, 1) ? 4095 : 0;
            end else begin
                target = $urandom_range(0, 4095);
            end
            for (int i = 0; i < run_len && sent < count; i++) begin
                if (kind >= 8) begin
                    v = $urandom_range(0, 4095);
                end else if (kind == 6) begin
                    v = target;
                end else begin
                    v = target + $urandom_range(0, 40) - 20;
                end
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                send_sample(12'(v), gap_pct);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: extremes, sum equal to offset
        send_sample(12'd0, 20);
        send_sample(12'hFFF, 20);
        for (int i = 0; i < 16; i++) begin
            send_sample(12'd2048, 20);
        end
        for (int i = 0; i < 3; i++) begin
            send_sample(12'd3048, 20);
        end
        send_sample(12'hAAA, 20);
        send_sample(12'h555, 20);
        send_sample(12'd1048, 20);
        send_sample(12'hFFF, 20);

        run_phase(1'b0, 2048, 150);
        run_phase(1'b1, 0, 200);
        run_phase(1'b1, 4095, 200);
        run_phase(1'b1, $urandom_range(0, 4095), 250);
        run_phase(1'b0, 0, 100);
        run_phase(1'b1, $urandom_range(0, 4095), 200);
        drain_requests();
        calm = 1'b1;
        run_phase(1'b1, $urandom_range(0, 4095), 200);

        drain_requests();
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
